// ----- rtl/pfr_pkg.sv -----
// Package for the page frame replacement block: sizes, policy codes and the
// structs passed between the controller and the frame cells. No dependencies.
package pfr_pkg;

    localparam int FRAMES  = 64;
    localparam int IDX_W   = $clog2(FRAMES);
    localparam int CNT_W   = IDX_W + 1;
    localparam int WORD_W  = 32;
    localparam int CFGI_W  = 2;

    localparam logic [2:0] POL_FIFO = 3'd0;
    localparam logic [2:0] POL_LRU  = 3'd1;
    localparam logic [2:0] POL_LFU  = 3'd2;
    localparam logic [2:0] POL_MFU  = 3'd3;

    localparam logic [CFGI_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFGI_W-1:0] REG_COUNT  = 2'd1;
    localparam logic [CFGI_W-1:0] REG_SEED   = 2'd2;

    localparam logic [WORD_W-1:0] ALL_ONES  = '1;
    localparam logic [WORD_W-1:0] LFSR_MASK = 32'h8020_0003;

    // Broadcast update to the cells.
    typedef struct packed {
        logic              touch_en;
        logic              alloc_en;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] stamp;
    } t_cell_cmd;

    // Best candidate so far, handed cell to cell.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] count;
        logic [WORD_W-1:0] touch;
        logic [WORD_W-1:0] alloc;
    } t_token;

    function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
        return (v == ALL_ONES) ? v : v + WORD_W'(1);
    endfunction

endpackage

// ----- rtl/pfr_cell.sv -----
// One frame cell: holds the frame's use count and stamps, and compares
// itself against the passing victim candidate. Depends on pfr_pkg.
module pfr_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pfr_pkg::IDX_W-1:0]    i_index,
    input  logic                         i_active,
    input  logic [2:0]                   i_policy,
    input  pfr_pkg::t_cell_cmd           i_cmd,
    input  pfr_pkg::t_token              i_tok,
    output pfr_pkg::t_token              o_tok
);

    logic [pfr_pkg::WORD_W-1:0] r_count;
    logic [pfr_pkg::WORD_W-1:0] r_touch;
    logic [pfr_pkg::WORD_W-1:0] r_alloc;
    pfr_pkg::t_token            r_tok;
    pfr_pkg::t_token            n_tok;
    logic                       better;
    logic                       take;

    always_comb begin
        case (i_policy)
            pfr_pkg::POL_FIFO: better = r_alloc < i_tok.alloc;
            pfr_pkg::POL_LRU:  better = r_touch < i_tok.touch;
            pfr_pkg::POL_LFU:  better = (r_count < i_tok.count) ||
                                        (r_count == i_tok.count && r_alloc < i_tok.alloc);
            pfr_pkg::POL_MFU:  better = (r_count > i_tok.count) ||
                                        (r_count == i_tok.count && r_alloc < i_tok.alloc);
            default:           better = 1'b0;
        endcase
        take = i_tok.valid && i_active && ((i_index == '0) || better);
        n_tok = i_tok;
        if (take) begin
            n_tok.idx   = i_index;
            n_tok.count = r_count;
            n_tok.touch = r_touch;
            n_tok.alloc = r_alloc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_touch   <= '0;
            r_alloc   <= '0;
            r_tok     <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.touch_en && i_cmd.idx == i_index) begin
                r_count <= pfr_pkg::sat_inc(r_count);
                r_touch <= i_cmd.stamp;
            end
            if (i_cmd.alloc_en && i_cmd.idx == i_index) begin
                r_alloc <= i_cmd.stamp;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/page_frame_replacement.sv -----
// Top level of the page frame replacement block: controller, clocks, LFSR
// and the chain of frame cells. Depends on pfr_pkg and pfr_cell.
//
//  channel  direction  handshake                 payload
//  in       to block   i_in_valid / o_in_stall   i_opcode, i_frame_index
//  out      from block o_out_valid / i_out_stall o_granted_frame, o_evicted, o_status
//  cfg      to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Touch items and fresh allocations are answered without leaving the idle state.
// An eviction by FIFO, LRU, LFU or MFU sends a candidate item along the
// 64-cell chain, one cell per cycle, and the winner comes out of the last cell.
// A random eviction steps the LFSR, scales it by a multiply, then gives the result.
// Synchronous reset clears all frame state at once; no clearing pass.
// Input stalls while an item is in progress or a full result register is stalled.
module page_frame_replacement (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [5:0]                   i_frame_index,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [5:0]                   o_granted_frame,
    output logic                         o_evicted,
    output logic                         o_status,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pfr_pkg::CFGI_W-1:0]   i_cfg_index,
    input  logic [pfr_pkg::WORD_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RAND, S_FIN} t_state;

    t_state                      r_state;
    logic                        r_out_valid;
    logic [pfr_pkg::IDX_W-1:0]   r_granted;
    logic                        r_evicted;
    logic                        r_status;
    logic [pfr_pkg::IDX_W-1:0]   r_victim;
    logic [2:0]                  r_policy;
    logic [pfr_pkg::CNT_W-1:0]   r_frame_count;
    logic [pfr_pkg::CNT_W-1:0]   r_fresh;
    logic [pfr_pkg::WORD_W-1:0]  r_touch_clk;
    logic [pfr_pkg::WORD_W-1:0]  r_alloc_clk;
    logic [pfr_pkg::WORD_W-1:0]  r_lfsr;

    logic                        out_free;
    logic                        in_acc;
    logic [pfr_pkg::CNT_W-1:0]   n_act;
    logic                        bad_touch;
    logic                        fresh_ok;
    logic                        is_rand;
    logic                        scan_start;
    logic [pfr_pkg::WORD_W+pfr_pkg::CNT_W-1:0] prod;
    pfr_pkg::t_cell_cmd          cmd;
    pfr_pkg::t_token             tok [pfr_pkg::FRAMES+1];

    // effective frame count: zero acts as one, above FRAMES clamps
    always_comb begin
        if (r_frame_count == '0) begin
            n_act = pfr_pkg::CNT_W'(1);
        end else if (r_frame_count > pfr_pkg::CNT_W'(pfr_pkg::FRAMES)) begin
            n_act = pfr_pkg::CNT_W'(pfr_pkg::FRAMES);
        end else begin
            n_act = r_frame_count;
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !(r_state == S_IDLE && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign bad_touch  = {1'b0, i_frame_index} >= n_act;
    assign fresh_ok   = r_fresh < n_act;
    assign is_rand    = r_policy > pfr_pkg::POL_MFU;
    assign scan_start = in_acc && i_opcode && !fresh_ok && !is_rand;
    assign prod       = r_lfsr * n_act;
    assign o_cfg_ready = 1'b1;

    // one update to the cells per cycle at most
    always_comb begin
        cmd = '0;
        if (in_acc && !i_opcode && !bad_touch) begin
            cmd.touch_en = 1'b1;
            cmd.idx      = i_frame_index;
            cmd.stamp    = pfr_pkg::sat_inc(r_touch_clk);
        end else if (in_acc && i_opcode && fresh_ok) begin
            cmd.alloc_en = 1'b1;
            cmd.idx      = r_fresh[pfr_pkg::IDX_W-1:0];
            cmd.stamp    = pfr_pkg::sat_inc(r_alloc_clk);
        end else if (r_state == S_FIN && out_free) begin
            cmd.alloc_en = 1'b1;
            cmd.idx      = r_victim;
            cmd.stamp    = pfr_pkg::sat_inc(r_alloc_clk);
        end
    end

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = scan_start;
    end

    for (genvar g = 0; g < pfr_pkg::FRAMES; g++) begin : g_cell
        pfr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (pfr_pkg::IDX_W'(g)),
            .i_active (pfr_pkg::CNT_W'(g) < n_act),
            .i_policy (r_policy),
            .i_cmd    (cmd),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_granted     <= '0;
            r_evicted     <= 1'b0;
            r_status      <= 1'b0;
            r_victim      <= '0;
            r_policy      <= pfr_pkg::POL_FIFO;
            r_frame_count <= pfr_pkg::CNT_W'(pfr_pkg::FRAMES);
            r_fresh       <= '0;
            r_touch_clk   <= '0;
            r_alloc_clk   <= '0;
            r_lfsr        <= pfr_pkg::WORD_W'(1);
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pfr_pkg::REG_POLICY: r_policy <= i_cfg_data[2:0];
                    pfr_pkg::REG_COUNT:  r_frame_count <= i_cfg_data[pfr_pkg::CNT_W-1:0];
                    pfr_pkg::REG_SEED:   r_lfsr <= (i_cfg_data == '0) ?
                                                   pfr_pkg::WORD_W'(1) : i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_opcode) begin
                            r_out_valid <= 1'b1;
                            r_granted   <= i_frame_index;
                            r_evicted   <= 1'b0;
                            r_status    <= bad_touch;
                            if (!bad_touch) begin
                                r_touch_clk <= cmd.stamp;
                            end
                        end else if (fresh_ok) begin
                            r_out_valid <= 1'b1;
                            r_granted   <= r_fresh[pfr_pkg::IDX_W-1:0];
                            r_evicted   <= 1'b0;
                            r_status    <= 1'b0;
                            r_fresh     <= r_fresh + pfr_pkg::CNT_W'(1);
                            r_alloc_clk <= cmd.stamp;
                        end else if (is_rand) begin
                            r_lfsr  <= r_lfsr[0] ? ((r_lfsr >> 1) ^ pfr_pkg::LFSR_MASK)
                                                 : (r_lfsr >> 1);
                            r_state <= S_RAND;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (tok[pfr_pkg::FRAMES].valid) begin
                        r_victim <= tok[pfr_pkg::FRAMES].idx;
                        r_state  <= S_FIN;
                    end
                end
                S_RAND: begin
                    // lfsr * n >> 32 is always below n
                    r_victim <= prod[pfr_pkg::WORD_W +: pfr_pkg::IDX_W];
                    r_state  <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_granted   <= r_victim;
                        r_evicted   <= 1'b1;
                        r_status    <= 1'b0;
                        r_alloc_clk <= cmd.stamp;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_frame = r_granted;
    assign o_evicted       = r_evicted;
    assign o_status        = r_status;

    a_tok_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[pfr_pkg::FRAMES].valid |-> r_state == S_SCAN)
        else $error("candidate left the chain outside a scan");

    a_fresh_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_opcode && fresh_ok) |=> (r_out_valid && !r_evicted))
        else $error("fresh allocation did not produce a plain grant");

    a_victim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |-> {1'b0, r_victim} < n_act)
        else $error("victim outside the active frames");

endmodule
